// ----- rtl/csmf_pkg.sv -----
// ----------------------------------------------------------------------------
// csmf_pkg
// Shared constants for the capacity-scaling max-flow block.
// ----------------------------------------------------------------------------
package csmf_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int CAP_BITS_DEF  = 16;

  localparam int TOT_W    = 20;
  localparam int IN_DW    = 24;  // from, to, capacity
  localparam int OUT_DW   = 24;  // total flow, zero padded
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 5;

  localparam logic [CFG_AW-1:0] CFG_SOURCE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SINK   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_NODES  = 2'd2;

endpackage

// ----- rtl/capacity_scaling_max_flow.sv -----
// ----------------------------------------------------------------------------
// capacity_scaling_max_flow
// Loads undirected edges into a residual RAM, then on the last edge runs
// capacity-scaling DFS augmentation and returns the max source-sink flow.
//
// Channel    Dir  Payload
// s_axis     in   tdata: edge_from[3:0] edge_to[7:4] edge_capacity[23:8]; tlast
// m_axis     out  tdata: max_flow_value[19:0]
// cfg        in   index 0 source, 1 sink, 2 node count
//
// An edge makes one RAM write per direction. The search is bound by the one
// residual RAM read port; each augmented edge is read and written once per
// direction. After reset and before every answer a pass clearing every RAM
// entry holds tready low. The answer waits in an output register until
// taken; no edge is accepted meanwhile.
// ----------------------------------------------------------------------------
module capacity_scaling_max_flow #(
  parameter int MAX_NODES = csmf_pkg::MAX_NODES_DEF,
  parameter int CAP_BITS  = csmf_pkg::CAP_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [csmf_pkg::IN_DW-1:0]  s_axis_tdata,  // edge_from, edge_to, edge_capacity
  input  logic                        s_axis_tlast,  // last_edge
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [csmf_pkg::OUT_DW-1:0] m_axis_tdata,  // max_flow_value
  input  logic                        cfg_we_i,
  input  logic [csmf_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [csmf_pkg::CFG_DW-1:0] cfg_data_i
);
  import csmf_pkg::*;

  localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW = NB + 1;
  localparam int AW = 2 * NB;
  localparam int RW = CAP_BITS + 1;

  localparam logic [4:0] ST_CLR0  = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_EDGE2 = 5'd2;
  localparam logic [4:0] ST_PRE   = 5'd3;
  localparam logic [4:0] ST_TOPRD = 5'd4;
  localparam logic [4:0] ST_TOPCK = 5'd5;
  localparam logic [4:0] ST_DLT   = 5'd6;
  localparam logic [4:0] ST_SINIT = 5'd7;
  localparam logic [4:0] ST_SSTEP = 5'd8;
  localparam logic [4:0] ST_SCHK  = 5'd9;
  localparam logic [4:0] ST_BRD   = 5'd10;
  localparam logic [4:0] ST_BCHK  = 5'd11;
  localparam logic [4:0] ST_URD1  = 5'd12;
  localparam logic [4:0] ST_UWR1  = 5'd13;
  localparam logic [4:0] ST_URD2  = 5'd14;
  localparam logic [4:0] ST_UWR2  = 5'd15;
  localparam logic [4:0] ST_CLRA  = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  logic [4:0]          state_q, state_d;
  logic [3:0]          src_q, snk_q;
  logic [4:0]          nc_q;
  logic [NB-1:0]       a_q, b_q;
  logic [RW-1:0]       cap_q;
  logic                ok_q, last_q;
  logic [NW-1:0]       i_q;
  logic [RW-1:0]       top_q;
  logic [CAP_BITS-1:0] delta_q;
  logic [MAX_NODES-1:0] vis_q;
  logic [NB-1:0]       dep_q, kk_q, prev_q, nxt_q;
  logic [RW-1:0]       bn_q;
  logic [TOT_W-1:0]    tot_q;
  logic [AW-1:0]       clr_q;

  logic [NB-1:0]       stk_v [MAX_NODES];
  logic [NW-1:0]       stk_p [MAX_NODES];

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, rd;

  logic [3:0]    a_in, b_in;
  logic          ok_in, s_acc, m_acc;
  logic [NW-1:0] n_eff;
  logic [NB-1:0] s_v, t_v, u_v, kn_v;
  logic [NW-1:0] p_v;
  logic          bad_cfg;

  assign a_in  = s_axis_tdata[3:0];
  assign b_in  = s_axis_tdata[7:4];
  assign ok_in = (a_in != b_in) && (32'(a_in) < MAX_NODES) && (32'(b_in) < MAX_NODES);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  assign n_eff   = (32'(nc_q) > MAX_NODES) ? NW'(MAX_NODES) : NW'(nc_q);
  assign s_v     = NB'(src_q);
  assign t_v     = NB'(snk_q);
  assign bad_cfg = (src_q == snk_q) || (32'(src_q) >= 32'(n_eff))
                || (32'(snk_q) >= 32'(n_eff));
  assign u_v     = stk_v[dep_q];
  assign p_v     = stk_p[dep_q];
  assign kn_v    = stk_v[NB'(kk_q + 1'b1)];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = OUT_DW'(tot_q);

  csmf_ram #(.WIDTH(RW), .DEPTH(1 << AW)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {a_q, b_q};
    ram_wdata = '0;
    ram_raddr = {prev_q, nxt_q};
    case (state_q)
      ST_CLR0, ST_CLRA: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      ST_IDLE: begin
        ram_we    = s_acc && ok_in;
        ram_waddr = {NB'(a_in), NB'(b_in)};
        ram_wdata = RW'(CAP_BITS'(s_axis_tdata[23:8]));
      end
      ST_EDGE2: begin
        ram_we    = ok_q;
        ram_waddr = {b_q, a_q};
        ram_wdata = cap_q;
      end
      ST_TOPRD: ram_raddr = {s_v, i_q[NB-1:0]};
      ST_SSTEP: ram_raddr = {u_v, p_v[NB-1:0]};
      ST_BRD:   ram_raddr = {prev_q, kn_v};
      ST_URD1:  ram_raddr = {prev_q, kn_v};
      ST_URD2:  ram_raddr = {nxt_q, prev_q};
      ST_UWR1: begin
        ram_we    = 1'b1;
        ram_waddr = {prev_q, nxt_q};
        ram_wdata = rd - bn_q;
      end
      ST_UWR2: begin
        ram_we    = 1'b1;
        ram_waddr = {nxt_q, prev_q};
        ram_wdata = rd + bn_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR0:  if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (s_acc) state_d = ST_EDGE2;
      ST_EDGE2: state_d = last_q ? ST_PRE : ST_IDLE;
      ST_PRE:   state_d = bad_cfg ? ST_CLRA : ST_TOPRD;
      ST_TOPRD: state_d = ST_TOPCK;
      ST_TOPCK: state_d = (i_q + 1'b1 == n_eff) ? ST_DLT : ST_TOPRD;
      ST_DLT: begin
        if (top_q == '0) state_d = ST_CLRA;
        else if ({delta_q, 1'b0} > top_q) state_d = ST_SINIT;
      end
      ST_SINIT: state_d = ST_SSTEP;
      ST_SSTEP: begin
        if (u_v == t_v) state_d = ST_BRD;
        else if (p_v >= n_eff) begin
          if (dep_q == '0) state_d = (delta_q == CAP_BITS'(1)) ? ST_CLRA : ST_SINIT;
        end else if (!vis_q[p_v[NB-1:0]]) state_d = ST_SCHK;
      end
      ST_SCHK:  state_d = ST_SSTEP;
      ST_BRD:   state_d = ST_BCHK;
      ST_BCHK:  state_d = (kk_q == dep_q - 1'b1) ? ST_URD1 : ST_BRD;
      ST_URD1:  state_d = ST_UWR1;
      ST_UWR1:  state_d = ST_URD2;
      ST_URD2:  state_d = ST_UWR2;
      ST_UWR2:  state_d = (kk_q == dep_q - 1'b1) ? ST_SINIT : ST_URD1;
      ST_CLRA:  if (clr_q == '1) state_d = ST_OUT;
      ST_OUT:   if (m_acc) state_d = ST_IDLE;
      default:  state_d = ST_CLR0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR0;
      src_q   <= 4'd0;
      snk_q   <= 4'd15;
      nc_q    <= 5'd16;
      ok_q    <= 1'b0;
      last_q  <= 1'b0;
      vis_q   <= '0;
      dep_q   <= '0;
      delta_q <= '0;
      tot_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE: src_q <= cfg_data_i[3:0];
          CFG_SINK:   snk_q <= cfg_data_i[3:0];
          CFG_NODES:  nc_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_CLR0, ST_CLRA: clr_q <= clr_q + 1'b1;
        ST_IDLE: if (s_acc) begin
          ok_q   <= ok_in;
          last_q <= s_axis_tlast;
        end
        ST_PRE: begin
          tot_q <= '0;
          i_q   <= '0;
          top_q <= '0;
        end
        ST_TOPCK: begin
          if (rd > top_q) top_q <= rd;
          i_q     <= i_q + 1'b1;
          delta_q <= CAP_BITS'(1);
        end
        ST_DLT: if ({delta_q, 1'b0} <= top_q) delta_q <= delta_q << 1;
        ST_SINIT: begin
          vis_q <= MAX_NODES'(1) << s_v;
          dep_q <= '0;
        end
        ST_SSTEP: begin
          if (u_v == t_v) begin
            kk_q   <= '0;
            prev_q <= stk_v[0];
            bn_q   <= '1;
          end else if (p_v >= n_eff) begin
            if (dep_q == '0) delta_q <= delta_q >> 1;
            else dep_q <= dep_q - 1'b1;
          end
        end
        ST_SCHK: if (rd >= RW'(delta_q)) begin
          vis_q[p_v[NB-1:0]] <= 1'b1;
          dep_q <= dep_q + 1'b1;
        end
        ST_BRD: nxt_q <= kn_v;
        ST_BCHK: begin
          if (rd < bn_q) bn_q <= rd;
          if (kk_q == dep_q - 1'b1) begin
            kk_q   <= '0;
            prev_q <= stk_v[0];
          end else begin
            kk_q   <= kk_q + 1'b1;
            prev_q <= nxt_q;
          end
        end
        ST_URD1: nxt_q <= kn_v;
        ST_UWR2: begin
          kk_q   <= kk_q + 1'b1;
          prev_q <= nxt_q;
          if (kk_q == dep_q - 1'b1) tot_q <= tot_q + TOT_W'(bn_q);
        end
        ST_OUT: if (m_acc) tot_q <= '0;
        default: ;
      endcase
    end
  end

  // payload: edge latch and search stack
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_acc) begin
      a_q   <= NB'(a_in);
      b_q   <= NB'(b_in);
      cap_q <= RW'(CAP_BITS'(s_axis_tdata[23:8]));
    end
    if (state_q == ST_SINIT) begin
      stk_v[0] <= s_v;
      stk_p[0] <= '0;
    end
    if (state_q == ST_SSTEP && u_v != t_v && p_v < n_eff && vis_q[p_v[NB-1:0]]) begin
      stk_p[dep_q] <= p_v + 1'b1;
    end
    if (state_q == ST_SSTEP && u_v != t_v && p_v >= n_eff) begin
      stk_p[dep_q] <= n_eff;
    end
    if (state_q == ST_SCHK) begin
      stk_p[dep_q] <= p_v + 1'b1;
      if (rd >= RW'(delta_q)) begin
        stk_v[NB'(dep_q + 1'b1)] <= p_v[NB-1:0];
        stk_p[NB'(dep_q + 1'b1)] <= '0;
      end
    end
  end

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken right after last edge");

  a_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("edge accepted while result pending");

  a_src_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SSTEP) |-> vis_q[s_v])
    else $error("source not marked during search");

endmodule

// ----- rtl/csmf_ram.sv -----
// ----------------------------------------------------------------------------
// csmf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module csmf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for capacity_scaling_max_flow. Random and directed edge
// lists are streamed in; a behavioural max-flow predictor computes the answer
// on each tlast transfer and a checker compares it with the output stream.
// ----------------------------------------------------------------------------
module tb;
  import csmf_pkg::*;

  localparam int NN = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i = CFG_SOURCE;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  capacity_scaling_max_flow dut (.*);

  always #5 clk_i = ~clk_i;

  logic [15:0] cap_m [NN][NN];
  int flow_m [NN][NN];
  logic [3:0] src_q = 4'd0, snk_q = 4'd15;
  logic [4:0] nodes_q = 5'd16;
  logic [TOT_W-1:0] flow_q [$];
  int errors = 0;
  int idle_pct = 28;
  int quiet = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int resid(int u, int v);
    return int'(cap_m[u][v]) - flow_m[u][v];
  endfunction

  // one DFS at step d, augments the first path found
  function automatic bit dfs_augment(int n, int s, int t, int d, ref int total);
    int stk [NN];
    int nxt [NN];
    int depth, u, i, b, r;
    bit [NN-1:0] seen;
    bit pushed;
    depth = 1; seen = '0; seen[s] = 1'b1; stk[0] = s; nxt[0] = 0;
    while (depth > 0) begin
      u = stk[depth-1];
      if (u == t) begin
        b = 32'h7fffffff;
        for (int k = 0; k + 1 < depth; k++) begin
          r = resid(stk[k], stk[k+1]);
          if (r < b) b = r;
        end
        for (int k = 0; k + 1 < depth; k++) begin
          flow_m[stk[k]][stk[k+1]] += b;
          flow_m[stk[k+1]][stk[k]] -= b;
        end
        total += b;
        return 1'b1;
      end
      pushed = 1'b0;
      for (i = nxt[depth-1]; i < n; i++) begin
        if (!seen[i] && resid(u, i) >= d) begin
          nxt[depth-1] = i + 1; seen[i] = 1'b1;
          stk[depth] = i; nxt[depth] = 0; depth++;
          pushed = 1'b1;
          break;
        end
      end
      if (!pushed) begin
        nxt[depth-1] = n;
        depth--;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [TOT_W-1:0] max_flow();
    int n, s, t, top, d, total;
    n = (nodes_q > NN) ? NN : int'(nodes_q);
    s = src_q; t = snk_q; top = 0; total = 0;
    if (s != t && s < n && t < n) begin
      for (int i = 0; i < n; i++) if (cap_m[s][i] > top) top = cap_m[s][i];
      if (top > 0) begin
        d = 1;
        while (d * 2 <= top) d *= 2;
        while (d >= 1) begin
          while (dfs_augment(n, s, t, d, total)) ;
          d = d >> 1;
        end
      end
    end
    return total[TOT_W-1:0];
  endfunction

  task automatic clear_graph();
    foreach (cap_m[u, v]) begin
      cap_m[u][v] = '0;
      flow_m[u][v] = 0;
    end
  endtask

  task automatic send_edge(input logic [3:0] a, input logic [3:0] b,
                           input logic [15:0] c, input bit last);
    while (($urandom % 100) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c, b, a};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (a != b) begin
      cap_m[a][b] = c;
      cap_m[b][a] = c;
    end
    if (last) begin
      flow_q = {flow_q, max_flow()};
      clear_graph();
    end
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (flow_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SOURCE: src_q = val[3:0];
      CFG_SINK: snk_q = val[3:0];
      default: nodes_q = val;
    endcase
  endtask

  task automatic set_graph_regs(input int s, input int t, input int n);
    write_reg(CFG_SOURCE, s[CFG_DW-1:0]);
    write_reg(CFG_SINK, t[CFG_DW-1:0]);
    write_reg(CFG_NODES, n[CFG_DW-1:0]);
  endtask

  task automatic random_graph(input int edges, input int n, input bit full_cap);
    logic [15:0] c;
    for (int e = 0; e < edges; e++) begin
      c = full_cap ? 16'($urandom) : 16'($urandom_range(0, 40));
      send_edge(4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)), c,
                e == edges - 1);
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom % 100) >= idle_pct;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (flow_q.size() == 0) begin
        report("answer with none expected");
      end else if (m_axis_tdata[TOT_W-1:0] !== flow_q[0]) begin
        report($sformatf("flow %0d, expected %0d", m_axis_tdata[TOT_W-1:0], flow_q[0]));
        void'(flow_q.pop_front());
      end else begin
        void'(flow_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 2000000) begin
      $display("FAIL capacity_scaling_max_flow");
      $finish;
    end
  end

  task automatic test_directed();
    send_edge(4'd0, 4'd15, 16'hffff, 1'b1);
    send_edge(4'd0, 4'd0, 16'd9, 1'b1);
    send_edge(4'd0, 4'd1, 16'd5, 1'b0);
    send_edge(4'd1, 4'd15, 16'd7, 1'b0);
    send_edge(4'd0, 4'd1, 16'd3, 1'b1);
    send_edge(4'd15, 4'd14, 16'h8000, 1'b1);
    send_edge(4'd0, 4'd5, 16'h7fff, 1'b0);
    send_edge(4'd5, 4'd15, 16'h0001, 1'b0);
    send_edge(4'd0, 4'd15, 16'h0000, 1'b1);
    send_edge(4'd3, 4'd4, 16'd1, 1'b1);
  endtask

  task automatic test_registers();
    set_graph_regs(3, 3, 16);
    send_edge(4'd3, 4'd4, 16'd10, 1'b1);
    set_graph_regs(2, 9, 8);
    send_edge(4'd2, 4'd9, 16'd10, 1'b0);
    send_edge(4'd2, 4'd5, 16'd10, 1'b1);
    set_graph_regs(0, 1, 2);
    send_edge(4'd0, 4'd1, 16'hffff, 1'b1);
    set_graph_regs(15, 0, 31);
    send_edge(4'd15, 4'd0, 16'd44, 1'b1);
  endtask

  task automatic test_random();
    int n, s, t;
    for (int g = 0; g < 150; g++) begin
      if (g == 60) idle_pct = 0;
      if (g == 90) idle_pct = 28;
      if (g % 10 == 0) begin
        n = $urandom_range(2, 16);
        s = $urandom_range(0, n - 1);
        t = $urandom_range(0, n - 1);
        if ($urandom_range(0, 9) == 0) t = $urandom_range(0, 15);
        set_graph_regs(s, t, ($urandom_range(0, 7) == 0) ? $urandom_range(16, 31) : n);
      end
      random_graph($urandom_range(1, 22), (nodes_q > 16) ? 16 : int'(nodes_q),
                   ($urandom_range(0, 2) == 0));
    end
  endtask

  initial begin
    clear_graph();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_registers();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (flow_q.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    if (errors == 0) begin
      $display("PASS capacity_scaling_max_flow");
    end else begin
      $display("FAIL capacity_scaling_max_flow");
    end
    $finish;
  end
endmodule
